// ===== hw/rtl/sca_pkg.sv =====
// shared constants, types and command/status structs for the string alignment scorer
// no dependencies; compiled before all other files
package sca_pkg;

  localparam int NEEDLE_MAX_DEF = 256;

  localparam int SCORE_W = 16;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] GAP_RST      = 7'd3;
  localparam logic [CFG_W-1:0] MATCH_RST    = 7'd2;
  localparam logic [CFG_W-1:0] MISMATCH_RST = 7'd2;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NAME = 1'b1;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

  // controller to datapath commands
  typedef struct packed {
    logic ld_needle;
    logic start_col;
    logic run_row;
    logic load_out;
  } sca_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic len_zero;
    logic row_last;
    logic name_last;
    logic out_free;
  } sca_sts_t;

endpackage

// ===== hw/rtl/sca_if.sv =====
// valid/ready channel interfaces for input bytes, scores and configuration writes
// depends on sca_pkg for field widths
interface sca_in_if
  import sca_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            func;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, func, ch, last, input ready);
  modport sink   (input valid, func, ch, last, output ready);
endinterface

interface sca_out_if
  import sca_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

interface sca_cfg_if
  import sca_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/string_alignment_scorer.sv =====
// Needle byte: taken while idle. Name byte: the one cell unit walks the column memory a
// row per cycle, then a finish state; on the last byte of a name the score is handed off
// once the output register is free. No new byte is taken until a name byte is through.
// A finished score waits in an output register while the next byte is taken.
// Reset (synchronous, active low): registers to gap 3, match 2, mismatch 2, empty needle,
// no result pending; no clearing pass, the first column of each name uses border values.
module string_alignment_scorer
  import sca_pkg::*;
#(
  parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sca_in_if.sink     in_chan,
  sca_out_if.source  out_chan,
  sca_cfg_if.sink    cfg_chan
);

  sca_cmd_t cmd;
  sca_sts_t sts;
  logic     in_rdy;

  assign in_chan.ready  = in_rdy;
  assign cfg_chan.ready = 1'b1;

  // controller
  sca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sca_dp #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_chan.ch),
    .in_last   (in_chan.last),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_score (out_chan.score)
  );

`ifndef SYNTHESIS
  // a pending score is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_chan.valid || out_chan.ready))
    else $error("score loaded over a pending result");

  // no transfer in while a column is being walked
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_row |-> !in_chan.ready)
    else $error("input ready during column walk");

  // a loaded score shows as valid on the next cycle
  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_chan.valid)
    else $error("loaded score not presented");
`endif

endmodule

// ===== hw/rtl/sca_ctrl.sv =====
// controller: sequences needle loads, column passes and result hand-off
// depends on sca_pkg for the command and status structs
module sca_ctrl
  import sca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_ready,
  input  sca_sts_t sts,
  output sca_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_NAME) begin
            cmd.start_col = 1'b1;
            state_nxt     = sts.len_zero ? ST_FIN : ST_RUN;
          end else begin
            cmd.ld_needle = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.run_row = 1'b1;
        if (sts.row_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = sts.name_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/sca_dp.sv =====
// datapath: config registers, needle and column memories, shared cell unit, best tracker
// depends on sca_pkg; driven by sca_ctrl commands
module sca_dp
  import sca_pkg::*;
#(
  parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sca_cmd_t                  cmd,
  output sca_sts_t                  sts,
  input  logic [CH_W-1:0]           in_ch,
  input  logic                      in_last,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [SCORE_W-1:0] out_score
);

  localparam int AW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int LW = $clog2(NEEDLE_MAX + 1);

  // configuration
  logic [CFG_W-1:0] gap_r, match_r, mism_r;

  // needle bookkeeping
  logic [LW-1:0] needle_len_r;
  logic          needle_done_r;
  logic          name_active_r;

  // column walk
  logic [AW-1:0]              row_r;
  logic [CH_W-1:0]            ch_r;
  logic                       last_r;
  logic                       first_r;
  logic signed [SCORE_W-1:0]  column_edge_r;
  logic signed [SCORE_W-1:0]  diag_r, up_r, border_r;
  logic signed [SCORE_W-1:0]  cell_r;
  logic                       cell_v_r;
  logic signed [SCORE_W-1:0]  best_r;
  logic                       out_valid_r;
  logic signed [SCORE_W-1:0]  out_score_r;

  // memories
  logic [CH_W-1:0]           needle_mem [NEEDLE_MAX];
  logic signed [SCORE_W-1:0] column_mem [NEEDLE_MAX];
  logic [CH_W-1:0]           nch_rd_r;
  logic signed [SCORE_W-1:0] col_rd_r;
  logic [AW-1:0]             rd_addr;

  logic signed [SCORE_W-1:0] gap16, match16, mism16;
  logic signed [SCORE_W-1:0] edge_base, edge_new;
  logic signed [SCORE_W-1:0] left, diag_term, up_term, left_term, cell_ab, cell_new;
  logic [LW-1:0]             len_base;
  logic                      len_room;

  assign gap16   = signed'({{(SCORE_W-CFG_W){1'b0}}, gap_r});
  assign match16 = signed'({{(SCORE_W-CFG_W){1'b0}}, match_r});
  assign mism16  = signed'({{(SCORE_W-CFG_W){1'b0}}, mism_r});

  // needle write position; a byte after a finished needle starts over
  assign len_base = needle_done_r ? '0 : needle_len_r;
  assign len_room = (len_base < LW'(NEEDLE_MAX));

  // row 0 value of the new column
  assign edge_base = name_active_r ? column_edge_r : '0;
  assign edge_new  = edge_base - gap16;

  // shared cell unit
  assign left      = first_r ? border_r : col_rd_r;
  assign diag_term = (nch_rd_r == ch_r) ? (diag_r + match16) : (diag_r - mism16);
  assign up_term   = up_r - gap16;
  assign left_term = left - gap16;
  assign cell_ab   = (diag_term > up_term) ? diag_term : up_term;
  assign cell_new  = (left_term > cell_ab) ? left_term : cell_ab;

  // next row read address
  assign rd_addr = cmd.run_row ? AW'(row_r + AW'(1)) : '0;

  // needle store, one port for loads and one for the column walk
  always_ff @(posedge clk) begin
    if (cmd.ld_needle && len_room) begin
      needle_mem[len_base[AW-1:0]] <= in_ch;
    end
    nch_rd_r <= needle_mem[rd_addr];
  end

  // column store
  always_ff @(posedge clk) begin
    if (cmd.run_row) begin
      column_mem[row_r] <= cell_new;
    end
    col_rd_r <= column_mem[rd_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= GAP_RST;
      match_r <= MATCH_RST;
      mism_r  <= MISMATCH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAP:      gap_r   <= cfg_data;
        REG_MATCH:    match_r <= cfg_data;
        REG_MISMATCH: mism_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // needle and name control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_len_r  <= '0;
      needle_done_r <= 1'b1;
      name_active_r <= 1'b0;
      column_edge_r <= '0;
      best_r        <= SCORE_MIN;
      cell_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cell_v_r <= cmd.run_row;
      if (cmd.ld_needle) begin
        name_active_r <= 1'b0;
        needle_len_r  <= len_room ? len_base + LW'(1) : len_base;
        needle_done_r <= in_last;
      end
      if (cmd.start_col) begin
        needle_done_r <= 1'b1;
        name_active_r <= 1'b1;
        column_edge_r <= edge_new;
      end
      // best over interior cells, taken from the registered cell value
      if (cmd.start_col && !name_active_r) begin
        best_r <= SCORE_MIN;
      end else if (cell_v_r && (cell_r > best_r)) begin
        best_r <= cell_r;
      end
      if (cmd.load_out) begin
        name_active_r <= 1'b0;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // column walk registers
  always_ff @(posedge clk) begin
    if (cmd.start_col) begin
      row_r    <= '0;
      ch_r     <= in_ch;
      last_r   <= in_last;
      first_r  <= !name_active_r;
      diag_r   <= edge_base;
      up_r     <= edge_new;
      border_r <= '0 - gap16;
    end else if (cmd.run_row) begin
      row_r    <= AW'(row_r + AW'(1));
      diag_r   <= left;
      up_r     <= cell_new;
      border_r <= border_r - gap16;
    end
    if (cmd.run_row) begin
      cell_r <= cell_new;
    end
    if (cmd.load_out) begin
      out_score_r <= best_r;
    end
  end

  // status to the controller
  assign sts.len_zero  = (needle_len_r == '0);
  assign sts.row_last  = (LW'(row_r) == needle_len_r - LW'(1));
  assign sts.name_last = last_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;

endmodule

// ===== bench/tb_string_alignment_scorer.sv =====
// self-checking bench for string_alignment_scorer: needle and name bytes in, best scores out
// needs sca_pkg and the sca_*_if interfaces from the rtl; scores are predicted per transfer
module tb_string_alignment_scorer;
  import sca_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_CYCLES  = 400;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] ch;
    logic            last;
  } byte_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sca_in_if  in_chan ();
  sca_out_if out_chan ();
  sca_cfg_if cfg_chan ();

  string_alignment_scorer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #2 clk = ~clk;

  // stimulus and expectations
  byte_item_t                pending_bytes[$];
  logic signed [SCORE_W-1:0] expected_scores[$];
  int  idle_pct    = 34;
  bit  want_stall  = 1'b0;
  bit  stall_taken = 1'b0;
  int  stall_left  = 0;
  bit  in_took     = 1'b0;
  int  err_count   = 0;
  int  cycle_count = 0;

  // predictor state: scoring settings, needle and current column
  logic [CFG_W-1:0]          gap_q      = GAP_RST;
  logic [CFG_W-1:0]          match_q    = MATCH_RST;
  logic [CFG_W-1:0]          mismatch_q = MISMATCH_RST;
  logic [CH_W-1:0]           needle_mem[NEEDLE_MAX_DEF];
  int                        needle_cnt    = 0;
  bit                        needle_closed = 1'b1;
  logic signed [SCORE_W-1:0] col_mem[NEEDLE_MAX_DEF];
  logic signed [SCORE_W-1:0] col_top = '0;
  logic signed [SCORE_W-1:0] best_cell = SCORE_MIN;
  bit                        in_name = 1'b0;

  // advance the alignment by one accepted byte, queueing a score at the end of a name
  function automatic void align_step(input byte_item_t it);
    logic signed [SCORE_W-1:0] diag_v, up_v, left_v, cell_v, cand_v;
    logic signed [SCORE_W-1:0] gap_s, match_s, miss_s;
    int i;
    gap_s   = {{(SCORE_W-CFG_W){1'b0}}, gap_q};
    match_s = {{(SCORE_W-CFG_W){1'b0}}, match_q};
    miss_s  = {{(SCORE_W-CFG_W){1'b0}}, mismatch_q};
    if (it.func == FUNC_LOAD) begin
      in_name   = 1'b0;
      col_top   = '0;
      best_cell = SCORE_MIN;
      if (needle_closed) begin
        needle_cnt    = 0;
        needle_closed = 1'b0;
      end
      if (needle_cnt < NEEDLE_MAX_DEF) begin
        needle_mem[needle_cnt] = it.ch;
        needle_cnt++;
      end
      if (it.last) needle_closed = 1'b1;
      return;
    end
    needle_closed = 1'b1;
    // borders at the first byte of a name
    if (!in_name) begin
      in_name   = 1'b1;
      col_top   = '0;
      best_cell = SCORE_MIN;
      for (i = 0; i < needle_cnt; i++)
        col_mem[i] = SCORE_W'(-(int'(gap_q) * (i + 1)));
    end
    diag_v  = col_top;
    col_top = col_top - gap_s;
    up_v    = col_top;
    for (i = 0; i < needle_cnt; i++) begin
      left_v = col_mem[i];
      cell_v = (needle_mem[i] == it.ch) ? diag_v + match_s : diag_v - miss_s;
      cand_v = up_v - gap_s;
      if (cand_v > cell_v) cell_v = cand_v;
      cand_v = left_v - gap_s;
      if (cand_v > cell_v) cell_v = cand_v;
      diag_v     = left_v;
      col_mem[i] = cell_v;
      up_v       = cell_v;
      if (cell_v > best_cell) best_cell = cell_v;
    end
    if (it.last) begin
      expected_scores.push_back(best_cell);
      in_name   = 1'b0;
      col_top   = '0;
      best_cell = SCORE_MIN;
    end
  endfunction

  // input driver: next byte from the queue, with random gaps
  always @(negedge clk) begin
    byte_item_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_took) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_chan.func  <= nxt.func;
        in_chan.ch    <= nxt.ch;
        in_chan.last  <= nxt.last;
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // score receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (want_stall && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left  = STALL_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor: scores checked, inputs and register writes fed to the predictor
  always @(posedge clk) begin
    logic signed [SCORE_W-1:0] exp_v;
    byte_item_t                seen;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end else if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_scores.size() == 0) begin
          $display("%0t: unexpected score transfer, expected none, actual %0d",
                   $time, out_chan.score);
          err_count++;
        end else begin
          exp_v = expected_scores.pop_front();
          if (out_chan.score !== exp_v) begin
            $display("%0t: score mismatch, expected %0d, actual %0d",
                     $time, exp_v, out_chan.score);
            err_count++;
          end
        end
      end
      in_took = in_chan.valid && in_chan.ready;
      if (in_took) begin
        seen.func = in_chan.func;
        seen.ch   = in_chan.ch;
        seen.last = in_chan.last;
        align_step(seen);
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_GAP:      gap_q      = cfg_chan.data;
          REG_MATCH:    match_q    = cfg_chan.data;
          REG_MISMATCH: mismatch_q = cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // byte source: mostly a small alphabet so that matches are common
  function automatic logic [CH_W-1:0] pick_ch();
    if ($urandom_range(99) < 70) return CH_W'($urandom_range(8'h64, 8'h61));
    return CH_W'($urandom_range(255));
  endfunction

  task automatic push_byte(input logic f, input logic [CH_W-1:0] c, input logic l);
    byte_item_t it;
    it.func = f;
    it.ch   = c;
    it.last = l;
    pending_bytes.push_back(it);
  endtask

  // a run of random bytes of one kind, last marked on the final one if asked
  task automatic push_run(input logic f, input int len, input bit close_it);
    int k;
    for (k = 0; k < len; k++)
      push_byte(f, pick_ch(), close_it && (k == len - 1));
  endtask

  // random traffic: mostly whole needles and names, some cut short, some stray bytes
  task automatic gen_traffic(input int n_items);
    int made, roll, len;
    len = $urandom_range(8, 1);
    push_run(FUNC_LOAD, len, 1'b1);
    made = len;
    while (made < n_items) begin
      roll = $urandom_range(99);
      if (roll < 14) begin
        len = $urandom_range(8, 1);
        push_run(FUNC_LOAD, len, 1'b1);
      end else if (roll < 80) begin
        len = $urandom_range(10, 1);
        push_run(FUNC_NAME, len, 1'b1);
      end else if (roll < 88) begin
        // name left open, a later needle byte abandons it
        len = $urandom_range(4, 1);
        push_run(FUNC_NAME, len, 1'b0);
      end else if (roll < 94) begin
        // needle left open, a name byte closes it
        len = $urandom_range(4, 1);
        push_run(FUNC_LOAD, len, 1'b0);
      end else begin
        len = 1;
        push_byte(1'($urandom_range(1)), CH_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
      made += len;
    end
  endtask

  // wait for every byte taken and every score back, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_chan.valid || expected_scores.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk);
    while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic set_scoring(input int g, input int m, input int mm);
    wait_drained();
    write_reg(REG_GAP, CFG_W'(g));
    write_reg(REG_MATCH, CFG_W'(m));
    write_reg(REG_MISMATCH, CFG_W'(mm));
  endtask

  initial begin
    int ph;
    in_chan.valid  = 1'b0;
    in_chan.func   = FUNC_LOAD;
    in_chan.ch     = '0;
    in_chan.last   = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = REG_GAP;
    cfg_chan.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty needle straight after reset
    push_byte(FUNC_NAME, 8'h41, 1'b1);
    // byte extremes in the needle and the name
    push_byte(FUNC_LOAD, 8'h00, 1'b0);
    push_byte(FUNC_LOAD, 8'hFF, 1'b1);
    push_byte(FUNC_NAME, 8'h00, 1'b0);
    push_byte(FUNC_NAME, 8'hFF, 1'b1);
    push_byte(FUNC_NAME, 8'hFF, 1'b0);
    push_byte(FUNC_NAME, 8'h00, 1'b0);
    push_byte(FUNC_NAME, 8'h7F, 1'b1);
    // open name abandoned by a needle byte, then a name during the needle load
    push_byte(FUNC_NAME, 8'h51, 1'b0);
    push_byte(FUNC_LOAD, 8'h41, 1'b0);
    push_byte(FUNC_NAME, 8'h41, 1'b1);
    // needle byte after that name starts a new needle
    push_byte(FUNC_LOAD, 8'h43, 1'b1);
    push_byte(FUNC_NAME, 8'h43, 1'b1);
    push_byte(FUNC_NAME, 8'h44, 1'b1);
    push_byte(FUNC_LOAD, 8'h80, 1'b0);
    push_byte(FUNC_LOAD, 8'h01, 1'b1);
    push_byte(FUNC_NAME, 8'h01, 1'b0);
    push_byte(FUNC_NAME, 8'h80, 1'b1);

    // all scoring terms zero
    set_scoring(0, 0, 0);
    gen_traffic(25);

    // all at the top, with a longer name
    set_scoring(127, 127, 127);
    push_run(FUNC_LOAD, 2, 1'b1);
    push_run(FUNC_NAME, 20, 1'b1);
    gen_traffic(20);

    // no gaps on either side for a whole phase
    set_scoring(0, 127, 0);
    idle_pct = 0;
    gen_traffic(40);

    // receiver holds off while the sender keeps offering bytes
    set_scoring(127, 0, 127);
    idle_pct   = 34;
    want_stall = 1'b1;
    gen_traffic(30);

    // needle longer than the store, then a few short names
    set_scoring(2, 5, 1);
    push_run(FUNC_LOAD, NEEDLE_MAX_DEF + 2, 1'b1);
    for (ph = 0; ph < 4; ph++)
      push_run(FUNC_NAME, $urandom_range(3, 1), 1'b1);
    gen_traffic(20);

    // random settings
    for (ph = 0; ph < 3; ph++) begin
      set_scoring($urandom_range(127), $urandom_range(127), $urandom_range(127));
      gen_traffic(25);
    end

    wait_drained();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
